@@ rtl/core/bis_pkg.sv @@
package bis_pkg;

	// Configuration registers are six bits wide.
	localparam int CFG_W = 6;
	typedef logic [CFG_W-1:0] cfg_data_t;

	// Register indexes on the write port.
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_ROW_LENGTH = 1'b0;
	localparam reg_idx_t REG_ROW_COUNT  = 1'b1;

	localparam int SIDE_MIN   = 2;
	localparam int SIDE_RESET = 8;

	localparam int IDX_W = 10;
	typedef logic [IDX_W-1:0] lin_idx_t;

	typedef struct packed {
		lin_idx_t grid_index;
		lin_idx_t seq_position;
		logic     is_interior;
		logic     last;
	} bis_res_t;

endpackage

@@ rtl/core/bis_if.sv @@
interface bis_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface bis_rsp_if;
	logic             valid;
	logic             ready;
	bis_pkg::lin_idx_t grid_index;
	bis_pkg::lin_idx_t seq_position;
	logic             is_interior;
	logic             last;

	modport source (output valid, output grid_index, output seq_position,
		output is_interior, output last, input ready);
	modport sink (input valid, input grid_index, input seq_position,
		input is_interior, input last, output ready);
endinterface

@@ rtl/core/boundary_interior_index_sequencer.sv @@
// Boundary-first, interior-second index sequencer.
// Each beat on req asks for the next entry of the scatter map of a
// row_length by row_count grid; each gives exactly one beat on rsp with
// the row-major grid_index, its seq_position, is_interior and last.
// A request with restart set returns position 0 and continues from there.
// Sides must be written on the wr_en/wr_index/wr_data port only while no
// request is in flight; the block itself does not enforce this. Any
// write puts the walk back to position 0.
// A request accepted on req is registered in the input stage; its result
// is loaded into the output register, which drives rsp.valid, when that
// register is free or is being drained.
// Throughput: one request per cycle while rsp does not stall, set by
// the single pass from the input register through the walker and one
// small multiply to the output register.
// When rsp is stalled the output register holds its beat, the input
// stage fills, and req.ready drops until the output drains.
// Reset clears both stages and loads eight by eight sides at position 0.
module boundary_interior_index_sequencer #(
	parameter int MAX_SIDE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	bis_req_if.sink             req,
	bis_rsp_if.source           rsp,
	input  logic                wr_en,
	input  bis_pkg::reg_idx_t   wr_index,
	input  bis_pkg::cfg_data_t  wr_data
);
	import bis_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CTR_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;

	logic [SIDE_W-1:0] nr, ns;
	logic              clear;
	logic              valid_s1, restart_s1;
	logic              valid_s2;
	bis_res_t          res, res_s2;
	logic              step;

	bis_cfg #(
		.MAX_SIDE (MAX_SIDE),
		.SIDE_W   (SIDE_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.nr       (nr),
		.ns       (ns),
		.clear    (clear)
	);

	bis_walker #(
		.SIDE_W (SIDE_W),
		.CTR_W  (CTR_W)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.step    (step),
		.restart (restart_s1),
		.nr      (nr),
		.ns      (ns),
		.res     (res)
	);

	assign step      = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			restart_s1 <= req.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.grid_index   = res_s2.grid_index;
	assign rsp.seq_position = res_s2.seq_position;
	assign rsp.is_interior  = res_s2.is_interior;
	assign rsp.last         = res_s2.last;

endmodule

@@ rtl/core/bis_cfg.sv @@
module bis_cfg #(
	parameter int MAX_SIDE = 32,
	parameter int SIDE_W   = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bis_pkg::reg_idx_t   wr_index,
	input  bis_pkg::cfg_data_t  wr_data,
	output logic [SIDE_W-1:0]   nr,
	output logic [SIDE_W-1:0]   ns,
	output logic                clear
);
	import bis_pkg::*;

	// Sides are held already clamped to the legal range.
	function automatic logic [SIDE_W-1:0] clamp_side(input cfg_data_t v);
		if (v < CFG_W'(SIDE_MIN))
			return SIDE_W'(SIDE_MIN);
		if (32'(v) > MAX_SIDE)
			return SIDE_W'(MAX_SIDE);
		return SIDE_W'(v);
	endfunction

	localparam logic [SIDE_W-1:0] SIDE_RST = clamp_side(CFG_W'(SIDE_RESET));

	logic [SIDE_W-1:0] nr_q;
	logic [SIDE_W-1:0] ns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_q <= SIDE_RST;
			ns_q <= SIDE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_LENGTH: nr_q <= clamp_side(wr_data);
				REG_ROW_COUNT:  ns_q <= clamp_side(wr_data);
				default: ;
			endcase
		end
	end

	assign nr    = nr_q;
	assign ns    = ns_q;
	// Any register write sends the walk back to its start.
	assign clear = wr_en && (wr_index == REG_ROW_LENGTH || wr_index == REG_ROW_COUNT);

endmodule

@@ rtl/core/bis_walker.sv @@
module bis_walker #(
	parameter int SIDE_W = 6,
	parameter int CTR_W  = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic               step,
	input  logic               restart,
	input  logic [SIDE_W-1:0]  nr,
	input  logic [SIDE_W-1:0]  ns,
	output bis_pkg::bis_res_t  res
);
	import bis_pkg::*;

	typedef enum logic [2:0] {
		PH_BOTTOM,
		PH_RIGHT,
		PH_TOP,
		PH_LEFT,
		PH_INT
	} phase_t;

	localparam int PROD_W = CTR_W + SIDE_W + 1;

	phase_t            phase_q, cur_phase, nxt_phase;
	logic [CTR_W-1:0]  row_q, col_q, cur_row, cur_col, nxt_row, nxt_col;
	lin_idx_t          seq_q, cur_seq, nxt_seq;
	logic              wrap;
	logic              has_int;
	logic [SIDE_W-1:0] row_w, col_w;
	logic [PROD_W-1:0] lin;

	always_comb begin
		if (restart) begin
			cur_phase = PH_BOTTOM;
			cur_row   = '0;
			cur_col   = '0;
			cur_seq   = '0;
		end else begin
			cur_phase = phase_q;
			cur_row   = row_q;
			cur_col   = col_q;
			cur_seq   = seq_q;
		end
	end

	assign row_w   = SIDE_W'(cur_row);
	assign col_w   = SIDE_W'(cur_col);
	assign has_int = (nr > SIDE_W'(2)) && (ns > SIDE_W'(2));

	always_comb begin
		nxt_phase = cur_phase;
		nxt_row   = cur_row;
		nxt_col   = cur_col;
		nxt_seq   = cur_seq + IDX_W'(1);
		wrap      = 1'b0;
		case (cur_phase)
			PH_BOTTOM: begin
				if (col_w < nr - SIDE_W'(1)) begin
					nxt_col = cur_col + CTR_W'(1);
				end else begin
					nxt_phase = PH_RIGHT;
					nxt_row   = CTR_W'(1);
					nxt_col   = CTR_W'(nr - SIDE_W'(1));
				end
			end
			PH_RIGHT: begin
				if (row_w < ns - SIDE_W'(1)) begin
					nxt_row = cur_row + CTR_W'(1);
				end else begin
					nxt_phase = PH_TOP;
					nxt_row   = CTR_W'(ns - SIDE_W'(1));
					nxt_col   = CTR_W'(nr - SIDE_W'(2));
				end
			end
			PH_TOP: begin
				if (cur_col != '0) begin
					nxt_col = cur_col - CTR_W'(1);
				end else if (ns > SIDE_W'(2)) begin
					nxt_phase = PH_LEFT;
					nxt_row   = CTR_W'(ns - SIDE_W'(2));
					nxt_col   = '0;
				end else begin
					// Two rows leave no left column and no interior.
					wrap = 1'b1;
				end
			end
			PH_LEFT: begin
				if (cur_row > CTR_W'(1)) begin
					nxt_row = cur_row - CTR_W'(1);
				end else if (has_int) begin
					nxt_phase = PH_INT;
					nxt_row   = CTR_W'(1);
					nxt_col   = CTR_W'(1);
				end else begin
					wrap = 1'b1;
				end
			end
			PH_INT: begin
				if (col_w < nr - SIDE_W'(2)) begin
					nxt_col = cur_col + CTR_W'(1);
				end else if (row_w < ns - SIDE_W'(2)) begin
					nxt_row = cur_row + CTR_W'(1);
					nxt_col = CTR_W'(1);
				end else begin
					wrap = 1'b1;
				end
			end
			default: begin
				nxt_phase = PH_BOTTOM;
				nxt_row   = '0;
				nxt_col   = '0;
				nxt_seq   = '0;
			end
		endcase
		if (wrap) begin
			nxt_phase = PH_BOTTOM;
			nxt_row   = '0;
			nxt_col   = '0;
			nxt_seq   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BOTTOM;
			row_q   <= '0;
			col_q   <= '0;
			seq_q   <= '0;
		end else if (clear) begin
			phase_q <= PH_BOTTOM;
			row_q   <= '0;
			col_q   <= '0;
			seq_q   <= '0;
		end else if (step) begin
			phase_q <= nxt_phase;
			row_q   <= nxt_row;
			col_q   <= nxt_col;
			seq_q   <= nxt_seq;
		end
	end

	assign lin = PROD_W'(cur_row) * PROD_W'(nr) + PROD_W'(cur_col);

	// The final entry is exactly the one after which the walk wraps.
	assign res.grid_index   = IDX_W'(lin);
	assign res.seq_position = cur_seq;
	assign res.is_interior  = (cur_phase == PH_INT);
	assign res.last         = wrap;

endmodule
